### rtl/ffha_pkg.sv
package ffha_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int ALIGN_BYTES  = 4;
  localparam int SLOTS        = HEAP_BYTES / ALIGN_BYTES;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int SIZE_W       = 21;
  localparam int LIMIT_W      = 17;
  localparam int SPLIT_MIN    = HEADER_BYTES + 4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_IGN  = 2'd2;

  // apb register addresses
  localparam logic [1:0] ADDR_HEAP_LIMIT = 2'd0;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              free;
    logic              nok;
    logic [SLOT_W-1:0] next;
    logic              pok;
    logic [SLOT_W-1:0] prev;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [4:0] {
    S_IDLE, S_WRD, S_WCHK, S_SP_W, S_SPN_RD, S_SPN_W, S_SPS_RD, S_SPS_W,
    S_MARK_RD, S_MARK_W, S_APP, S_TL_RD, S_TL_W, S_F_RD, S_F_W, S_FN_RD,
    S_FN_CHK, S_J_RD, S_J_W, S_FP_RD0, S_FP_CHK0, S_FP_RD, S_FP_CHK, S_DONE,
    S_FIN
  } state_t;

endpackage

### rtl/ffha_req_if.sv
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] alloc_size;
  logic [15:0] free_address;
  modport source (output valid, op, alloc_size, free_address, input ready);
  modport sink (input valid, op, alloc_size, free_address, output ready);
endinterface

### rtl/ffha_rsp_if.sv
interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_address;
  logic [1:0]  status;
  modport source (output valid, data_address, status, input ready);
  modport sink (input valid, data_address, status, output ready);
endinterface

### rtl/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/first_fit_heap_allocator.sv
// first-fit heap allocator over a 64 KiB heap. chunk headers (size, free mark,
// next and previous links) live in a single-port-read synchronous header ram,
// one entry per 4-byte slot, so the ram needs no clearing pass after reset. an
// allocate walks the chain from offset 0, reading one header per visited chunk,
// then splits, marks or appends (the very first allocate skips the walk); a
// free marks the chunk and merges it with free neighbours, while an ignored
// free goes straight to finish. the transaction is accepted in idle. one
// transaction is worked on at a time; a finished result sits in an output
// register so the next request may be taken while it waits, and a second
// finished result holds in finish until that register drains. heap_limit is
// written over the apb port at address 0.
module first_fit_heap_allocator
  import ffha_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  ffha_req_if.sink      req,
  ffha_rsp_if.source    rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  state_t state, state_next;

  // header ram port
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  hdr_t              ram_wdata, rd;
  logic [HDR_W-1:0]  ram_rdata;

  // working registers
  logic [SLOT_W-1:0]  cur, cur_next;       // chunk being visited / freed
  logic [SLOT_W-1:0]  last, last_next;     // tail of the walk
  logic               tail_v, tail_v_next;
  logic [SLOT_W-1:0]  sa, sa_next;         // split slot, new chunk or prev chunk
  logic [SLOT_W-1:0]  jn, jn_next;         // chunk whose back link is patched
  logic [SLOT_W-1:0]  jpv, jpv_next;
  logic               jlast, jlast_next;
  logic [16:0]        rs, rs_next;         // rounded size
  logic [SLOT_W:0]    steps, steps_next;
  hdr_t               ha, ha_next;
  logic [15:0]        res_data, res_data_next;
  logic [1:0]         res_status, res_status_next;

  // architectural state
  logic [LIMIT_W-1:0] brk, brk_next;
  logic               started, started_next;
  logic [LIMIT_W-1:0] heap_limit;

  // output register
  logic        ovalid, ovalid_next;
  logic [15:0] odata, odata_next;
  logic [1:0]  ostat, ostat_next;

  ffha_ram #(.WIDTH(HDR_W), .DEPTH(SLOTS)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = hdr_t'(ram_rdata);

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_HEAP_LIMIT) ? {{(32-LIMIT_W){1'b0}}, heap_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= LIMIT_W'(HEAP_BYTES);
    end else if (psel && penable && pwrite && pready) begin
      heap_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = ovalid;
  assign rsp.data_address = odata;
  assign rsp.status       = ostat;

  // combinational helpers
  logic [16:0]        rs_in;
  logic [SIZE_W:0]    fit_diff;
  logic [SLOT_W-1:0]  split_slot;
  logic [SLOT_W:0]    steps_inc;
  logic [17:0]        lim, need, room;
  logic [SLOT_W-1:0]  at_slot;
  logic [15:0]        fa_off;
  logic               free_ign;

  always_comb begin
    rs_in      = (17'(req.alloc_size) + 17'(ALIGN_BYTES - 1)) &
                 ~17'(ALIGN_BYTES - 1);
    fit_diff   = {1'b0, ha.size} - (SIZE_W+1)'(rs);
    split_slot = SLOT_W'(cur + SLOT_W'(rs >> 2) + SLOT_W'(HEADER_BYTES / ALIGN_BYTES));
    steps_inc  = steps + 1'b1;
    lim        = (18'(heap_limit) < 18'(HEAP_BYTES)) ? 18'(heap_limit) : 18'(HEAP_BYTES);
    need       = 18'(HEADER_BYTES) + 18'(rs);
    room       = lim - 18'(brk);
    at_slot    = SLOT_W'(brk >> 2);
    fa_off     = req.free_address - 16'(HEADER_BYTES);
    free_ign   = (req.free_address == 16'd0) || !started ||
                 (17'(req.free_address) > brk) ||
                 (req.free_address < 16'(HEADER_BYTES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      brk     <= '0;
      started <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      state   <= state_next;
      brk     <= brk_next;
      started <= started_next;
      ovalid  <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    last       <= last_next;
    tail_v     <= tail_v_next;
    sa         <= sa_next;
    jn         <= jn_next;
    jpv        <= jpv_next;
    jlast      <= jlast_next;
    rs         <= rs_next;
    steps      <= steps_next;
    ha         <= ha_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    odata      <= odata_next;
    ostat      <= ostat_next;
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    last_next       = last;
    tail_v_next     = tail_v;
    sa_next         = sa;
    jn_next         = jn;
    jpv_next        = jpv;
    jlast_next      = jlast;
    rs_next         = rs;
    steps_next      = steps;
    ha_next         = ha;
    res_data_next   = res_data;
    res_status_next = res_status;
    brk_next        = brk;
    started_next    = started;
    ovalid_next     = ovalid;
    odata_next      = odata;
    ostat_next      = ostat;
    ram_we          = 1'b0;
    ram_waddr       = cur;
    ram_wdata       = rd;
    ram_raddr       = cur;

    if (rsp.valid && rsp.ready) begin
      ovalid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.op == OP_ALLOC) begin
            rs_next     = rs_in;
            tail_v_next = 1'b0;
            cur_next    = '0;
            steps_next  = '0;
            state_next  = started ? S_WRD : S_APP;
          end else if (free_ign) begin
            res_data_next   = '0;
            res_status_next = ST_IGN;
            state_next      = S_FIN;
          end else begin
            cur_next   = SLOT_W'(fa_off >> 2);
            state_next = S_F_RD;
          end
        end
      end

      // first-fit walk, one header per read
      S_WRD: begin
        ram_raddr  = cur;
        state_next = S_WCHK;
      end
      S_WCHK: begin
        if (rd.free && ({1'b0, rd.size} >= (SIZE_W+1)'(rs))) begin
          ha_next    = rd;
          state_next = S_MARK_RD;
          if (({1'b0, rd.size} - (SIZE_W+1)'(rs)) >= (SIZE_W+1)'(SPLIT_MIN)) begin
            state_next = S_SP_W;
          end
        end else begin
          last_next   = cur;
          tail_v_next = 1'b1;
          steps_next  = steps_inc;
          if (!rd.nok || (steps_inc > (SLOT_W+1)'(SLOTS))) begin
            state_next = S_APP;
          end else begin
            cur_next   = rd.next;
            state_next = S_WRD;
          end
        end
      end

      // split: spare chunk, its successor's back link, then the chunk itself
      S_SP_W: begin
        ram_we         = 1'b1;
        ram_waddr      = split_slot;
        ram_wdata      = ha;
        ram_wdata.size = SIZE_W'(fit_diff - (SIZE_W+1)'(HEADER_BYTES));
        ram_wdata.free = 1'b1;
        ram_wdata.pok  = 1'b1;
        ram_wdata.prev = cur;
        sa_next        = split_slot;
        if (ha.nok) begin
          jn_next    = ha.next;
          state_next = S_SPN_RD;
        end else begin
          state_next = S_SPS_RD;
        end
      end
      S_SPN_RD: begin
        ram_raddr  = jn;
        state_next = S_SPN_W;
      end
      S_SPN_W: begin
        ram_we         = 1'b1;
        ram_waddr      = jn;
        ram_wdata      = rd;
        ram_wdata.prev = sa;
        ram_wdata.pok  = 1'b1;
        state_next     = S_SPS_RD;
      end
      S_SPS_RD: begin
        ram_raddr  = cur;
        state_next = S_SPS_W;
      end
      S_SPS_W: begin
        ram_we          = 1'b1;
        ram_waddr       = cur;
        ram_wdata       = rd;
        ram_wdata.next  = sa;
        ram_wdata.nok   = 1'b1;
        ram_wdata.size  = SIZE_W'(rs);
        ram_wdata.free  = 1'b0;
        res_data_next   = 16'({cur, 2'b00}) + 16'(HEADER_BYTES);
        res_status_next = ST_DONE;
        state_next      = S_FIN;
      end

      // whole chunk taken
      S_MARK_RD: begin
        ram_raddr  = cur;
        state_next = S_MARK_W;
      end
      S_MARK_W: begin
        ram_we          = 1'b1;
        ram_waddr       = cur;
        ram_wdata       = rd;
        ram_wdata.free  = 1'b0;
        res_data_next   = 16'({cur, 2'b00}) + 16'(HEADER_BYTES);
        res_status_next = ST_DONE;
        state_next      = S_FIN;
      end

      // grow the break
      S_APP: begin
        if ((18'(brk) > lim) || (need > room)) begin
          res_data_next   = '0;
          res_status_next = ST_OOM;
          state_next      = S_FIN;
        end else begin
          ram_we          = 1'b1;
          ram_waddr       = at_slot;
          ram_wdata.size  = SIZE_W'(rs);
          ram_wdata.free  = 1'b0;
          ram_wdata.nok   = 1'b0;
          ram_wdata.next  = '0;
          ram_wdata.pok   = tail_v;
          ram_wdata.prev  = tail_v ? last : '0;
          brk_next        = LIMIT_W'(18'(brk) + need);
          started_next    = 1'b1;
          sa_next         = at_slot;
          res_data_next   = 16'(brk) + 16'(HEADER_BYTES);
          res_status_next = ST_DONE;
          state_next      = tail_v ? S_TL_RD : S_FIN;
        end
      end
      S_TL_RD: begin
        ram_raddr  = last;
        state_next = S_TL_W;
      end
      S_TL_W: begin
        ram_we         = 1'b1;
        ram_waddr      = last;
        ram_wdata      = rd;
        ram_wdata.next = sa;
        ram_wdata.nok  = 1'b1;
        state_next     = S_FIN;
      end

      // free: mark, merge with next, then with prev
      S_F_RD: begin
        ram_raddr  = cur;
        state_next = S_F_W;
      end
      S_F_W: begin
        ram_we         = 1'b1;
        ram_waddr      = cur;
        ram_wdata      = rd;
        ram_wdata.free = 1'b1;
        ha_next        = rd;
        ha_next.free   = 1'b1;
        if (rd.nok) begin
          jn_next    = rd.next;
          state_next = S_FN_RD;
        end else begin
          state_next = S_FP_RD0;
        end
      end
      S_FN_RD: begin
        ram_raddr  = jn;
        state_next = S_FN_CHK;
      end
      S_FN_CHK: begin
        state_next = S_FP_RD0;
        if (rd.free) begin
          ram_we         = 1'b1;
          ram_waddr      = cur;
          ram_wdata      = ha;
          ram_wdata.size = SIZE_W'(ha.size + rd.size + SIZE_W'(HEADER_BYTES));
          ram_wdata.next = rd.next;
          ram_wdata.nok  = rd.nok;
          if (rd.nok) begin
            jn_next    = rd.next;
            jpv_next   = cur;
            jlast_next = 1'b0;
            state_next = S_J_RD;
          end
        end
      end
      S_J_RD: begin
        ram_raddr  = jn;
        state_next = S_J_W;
      end
      S_J_W: begin
        ram_we         = 1'b1;
        ram_waddr      = jn;
        ram_wdata      = rd;
        ram_wdata.prev = jpv;
        ram_wdata.pok  = 1'b1;
        state_next     = jlast ? S_DONE : S_FP_RD0;
      end
      S_FP_RD0: begin
        ram_raddr  = cur;
        state_next = S_FP_CHK0;
      end
      S_FP_CHK0: begin
        ha_next = rd;
        if (rd.pok) begin
          sa_next    = rd.prev;
          state_next = S_FP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FP_RD: begin
        ram_raddr  = sa;
        state_next = S_FP_CHK;
      end
      S_FP_CHK: begin
        state_next = S_DONE;
        if (rd.free) begin
          ram_we         = 1'b1;
          ram_waddr      = sa;
          ram_wdata      = rd;
          ram_wdata.size = SIZE_W'(rd.size + ha.size + SIZE_W'(HEADER_BYTES));
          ram_wdata.next = ha.next;
          ram_wdata.nok  = ha.nok;
          if (ha.nok) begin
            jn_next    = ha.next;
            jpv_next   = sa;
            jlast_next = 1'b1;
            state_next = S_J_RD;
          end
        end
      end
      S_DONE: begin
        res_data_next   = '0;
        res_status_next = ST_DONE;
        state_next      = S_FIN;
      end

      // hand the result to the output register once it is free
      S_FIN: begin
        if (!ovalid || rsp.ready) begin
          ovalid_next = 1'b1;
          odata_next  = res_data;
          ostat_next  = res_status;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### verif/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow copy of the heap: one header per 4-byte slot, links held as offsets
  // ---------------------------------------------------------------------------
  int unsigned hdr_size [SLOTS];
  bit          hdr_free [SLOTS];
  int unsigned hdr_next [SLOTS];
  bit          hdr_nok  [SLOTS];
  int unsigned hdr_prev [SLOTS];
  bit          hdr_pok  [SLOTS];
  int unsigned brk = 0;
  bit          started = 1'b0;
  int unsigned limit_reg = 65536;

  // addresses ever granted (so a stale free always reads a written header)
  logic [15:0] granted [$];
  logic [15:0] live [$];

  typedef struct packed {
    logic [15:0] data_address;
    logic [1:0]  status;
  } grant_t;
  grant_t pending_grants [$];

  int fails = 0;
  int n_done = 0, n_oom = 0, n_ign = 0;
  int cycles = 0;
  bit hold_req = 1'b0;

  function automatic int unsigned slot_of(int unsigned off);
    return (off / ALIGN_BYTES) % SLOTS;
  endfunction

  function automatic void merge_chunks(int unsigned a, int unsigned b);
    int unsigned sa, sb;
    sa = slot_of(a);
    sb = slot_of(b);
    hdr_size[sa] = (hdr_size[sa] + hdr_size[sb] + HEADER_BYTES) & 32'h1F_FFFF;
    hdr_next[sa] = hdr_next[sb];
    hdr_nok[sa]  = hdr_nok[sb];
    if (hdr_nok[sb]) begin
      hdr_prev[slot_of(hdr_next[sb])] = a;
      hdr_pok[slot_of(hdr_next[sb])]  = 1'b1;
    end
  endfunction

  // grow the heap at the break; fails without touching state past the limit
  function automatic bit grow_heap(bit has_tail, int unsigned tail, int unsigned rs,
                                   output int unsigned at);
    int unsigned lim, need, s;
    lim  = (limit_reg < HEAP_BYTES) ? limit_reg : HEAP_BYTES;
    need = HEADER_BYTES + rs;
    at   = brk;
    if (at > lim || need > lim - at) return 1'b0;
    brk = at + need;
    s = slot_of(at);
    hdr_size[s] = rs;
    hdr_free[s] = 1'b0;
    hdr_nok[s]  = 1'b0;
    hdr_next[s] = 0;
    hdr_pok[s]  = has_tail;
    hdr_prev[s] = has_tail ? tail : 0;
    if (has_tail) begin
      hdr_next[slot_of(tail)] = at;
      hdr_nok[slot_of(tail)]  = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic grant_t predict_heap(logic op, logic [15:0] asz, logic [15:0] fa);
    grant_t g;
    int unsigned rs, cur, last, steps, s, sp, ss, where, h;
    bit have, found, ok;
    g = '0;
    if (op == OP_ALLOC) begin
      rs = (int'(asz) + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
      where = 0;
      if (started) begin
        cur = 0; last = 0; steps = 0; have = 1'b1; found = 1'b0;
        // first fit, bounded so a broken chain cannot spin forever
        while (have && steps <= SLOTS) begin
          s = slot_of(cur);
          if (hdr_free[s] && hdr_size[s] >= rs) begin
            found = 1'b1;
            break;
          end
          last = cur;
          have = hdr_nok[s];
          cur = hdr_next[s];
          steps++;
        end
        if (found) begin
          s = slot_of(cur);
          if (hdr_size[s] - rs >= SPLIT_MIN) begin
            sp = cur + rs + HEADER_BYTES;
            ss = slot_of(sp);
            hdr_size[ss] = hdr_size[s] - rs - HEADER_BYTES;
            hdr_next[ss] = hdr_next[s];
            hdr_nok[ss]  = hdr_nok[s];
            hdr_prev[ss] = cur;
            hdr_pok[ss]  = 1'b1;
            hdr_free[ss] = 1'b1;
            // successor now points back at the spare chunk
            if (hdr_nok[s]) begin
              hdr_prev[slot_of(hdr_next[s])] = sp;
              hdr_pok[slot_of(hdr_next[s])]  = 1'b1;
            end
            hdr_next[s] = sp;
            hdr_nok[s]  = 1'b1;
            hdr_size[s] = rs;
          end
          hdr_free[s] = 1'b0;
          where = cur;
          ok = 1'b1;
        end else begin
          ok = grow_heap(1'b1, last, rs, where);
        end
      end else begin
        ok = grow_heap(1'b0, 0, rs, where);
        if (ok) started = 1'b1;
      end
      if (ok) begin
        g.data_address = 16'(where + HEADER_BYTES);
        g.status = ST_DONE;
      end else begin
        g.status = ST_OOM;
      end
    end else begin
      if (fa == 0 || !started || fa > brk || fa < HEADER_BYTES) begin
        g.status = ST_IGN;
      end else begin
        h = fa - HEADER_BYTES;
        s = slot_of(h);
        hdr_free[s] = 1'b1;
        if (hdr_nok[s] && hdr_free[slot_of(hdr_next[s])]) merge_chunks(h, hdr_next[s]);
        if (hdr_pok[s] && hdr_free[slot_of(hdr_prev[s])]) merge_chunks(hdr_prev[s], h);
        g.status = ST_DONE;
      end
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  task automatic push_request(logic op, logic [15:0] asz, logic [15:0] fa,
                              bit typed, grant_t typed_grant);
    grant_t g;
    int idx;
    req.valid <= 1'b1;
    req.op <= op;
    req.alloc_size <= asz;
    req.free_address <= fa;
    // ready is stable between the falling edge and the next rising edge
    do @(negedge clk); while (!req.ready);
    g = predict_heap(op, asz, fa);
    if (op == OP_ALLOC && g.status == ST_DONE) begin
      granted.push_back(g.data_address);
      live.push_back(g.data_address);
    end
    if (op == OP_FREE && g.status == ST_DONE) begin
      for (idx = 0; idx < live.size(); idx++)
        if (live[idx] == fa) begin
          live.delete(idx);
          break;
        end
    end
    pending_grants.push_back(typed ? typed_grant : g);
    @(posedge clk);
  endtask

  task automatic sender_gap();
    int r, n;
    r = $urandom_range(99);
    if (r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    if (req.valid) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // heap_limit sits at address 0; write lands on the access cycle edge
  task automatic write_limit(int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_HEAP_LIMIT;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_reg = v & 32'h1_FFFF;
  endtask

  // mostly well-formed alloc/free traffic, some noise frees
  task automatic random_item();
    int r;
    logic [15:0] asz, fa;
    r = $urandom_range(99);
    asz = '0;
    fa = '0;
    if (r < 50) begin
      r = $urandom_range(99);
      if (r < 80) asz = 16'($urandom_range(0, 192));
      else if (r < 95) asz = 16'($urandom_range(0, 2048));
      else asz = 16'($urandom);
      push_request(OP_ALLOC, asz, 16'($urandom), 1'b0, '0);
    end else begin
      r = $urandom_range(99);
      if (r < 70 && live.size() > 0) fa = live[$urandom_range(0, live.size() - 1)];
      else if (r < 80 && granted.size() > 0)
        fa = granted[$urandom_range(0, granted.size() - 1)];
      else if (r < 87) fa = '0;
      else if (r < 93) fa = 16'($urandom_range(1, HEADER_BYTES - 1));
      else if (brk < 65535) fa = 16'($urandom_range(brk + 1, 65535));
      else fa = '0;
      push_request(OP_FREE, 16'($urandom), fa, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed table; typed results only where obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    int          set_limit;   // -1 leaves heap_limit alone
    logic        op;
    logic [15:0] asz;
    logic [15:0] fa;
    bit          typed;
    logic [15:0] d;
    logic [1:0]  st;
  } row_t;

  row_t rows [$];

  function automatic row_t mk(int lim, logic op, logic [15:0] asz, logic [15:0] fa,
                              bit typed, logic [15:0] d, logic [1:0] st);
    row_t r;
    r.set_limit = lim; r.op = op; r.asz = asz; r.fa = fa;
    r.typed = typed; r.d = d; r.st = st;
    return r;
  endfunction

  initial begin
    // zero limit: nothing fits, frees on an empty heap ignored
    rows.push_back(mk(0,      OP_ALLOC, 16'd0,     16'd0,     1, 16'd0,  ST_OOM));
    rows.push_back(mk(-1,     OP_FREE,  16'hFFFF,  16'd0,     1, 16'd0,  ST_IGN));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd100,   1, 16'd0,  ST_IGN));
    // widest limit, effective 64 KiB
    rows.push_back(mk(131071, OP_ALLOC, 16'hFFFF,  16'hFFFF,  1, 16'd0,  ST_OOM));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd0,     16'd0,     1, 16'd16, ST_DONE));
    // free of the address equal to the break is accepted
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd16,    1, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd1,     16'd0,     1, 16'd32, ST_DONE));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd100,   16'd0,     1, 16'd52, ST_DONE));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd40,    16'd0,     0, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd52,    0, 16'd0,  ST_DONE));
    // first fit with split into a spare chunk
    rows.push_back(mk(-1,     OP_ALLOC, 16'd8,     16'd0,     0, 16'd0,  ST_DONE));
    // merges with a free predecessor and a free successor
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd32,    0, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd168,   0, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd52,    0, 16'd0,  ST_DONE));
    // stale free of an already freed chunk
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd52,    0, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd7,     1, 16'd0,  ST_IGN));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'd15,    1, 16'd0,  ST_IGN));
    rows.push_back(mk(-1,     OP_FREE,  16'd0,     16'hFFFF,  1, 16'd0,  ST_IGN));
    rows.push_back(mk(-1,     OP_FREE,  16'hFFFF,  16'd0,     1, 16'd0,  ST_IGN));
    rows.push_back(mk(-1,     OP_ALLOC, 16'hFFFF,  16'd0,     1, 16'd0,  ST_OOM));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd3,     16'd0,     0, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd16,    16'd0,     0, 16'd0,  ST_DONE));
    rows.push_back(mk(-1,     OP_ALLOC, 16'd200,   16'd0,     0, 16'd0,  ST_DONE));
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int r, n;
    rsp.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(99);
        if (r < 65) n = 0;
        else if (r < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 50);
        if (n > 0) begin
          rsp.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        rsp.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // compare at the falling edge, where the handshake is already settled
  always @(negedge clk) begin
    grant_t exp_g;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected transaction: data_address %0d status %0d",
               rsp.data_address, rsp.status);
        fails++;
      end else begin
        exp_g = pending_grants.pop_front();
        if (rsp.data_address !== exp_g.data_address) begin
          $error("data_address: expected %0d, got %0d", exp_g.data_address,
                 rsp.data_address);
          fails++;
        end
        if (rsp.status !== exp_g.status) begin
          $error("status: expected %0d, got %0d", exp_g.status, rsp.status);
          fails++;
        end
        if (exp_g.status == ST_OOM) n_oom++;
        else if (exp_g.status == ST_IGN) n_ign++;
        else n_done++;
      end
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req.valid = 1'b0;
    req.op = OP_ALLOC;
    req.alloc_size = '0;
    req.free_address = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_limit >= 0) begin
        wait_drained();
        write_limit(rows[i].set_limit);
      end
      push_request(rows[i].op, rows[i].asz, rows[i].fa, rows[i].typed,
                   '{data_address: rows[i].d, status: rows[i].st});
      sender_gap();
    end

    // random traffic under the last limit set by the table
    repeat (200) begin
      random_item();
      sender_gap();
    end

    // sender pauses until everything is back
    wait_drained();
    write_limit(40000);
    hold_req = 1'b1;
    repeat (150) random_item();
    repeat (50) begin
      random_item();
      sender_gap();
    end

    wait_drained();
    write_limit(65536);
    repeat (150) begin
      random_item();
      sender_gap();
    end

    wait_drained();
    repeat (50) @(posedge clk);

    $display("tb: %0d grants/frees done, %0d out of memory, %0d frees ignored",
             n_done, n_oom, n_ign);
    $display("tb: heap_limit 0, 40000, 65536 and 131071; break ended at %0d", brk);
    if (fails == 0 && pending_grants.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ffha_pkg.sv
rtl/ffha_req_if.sv
rtl/ffha_rsp_if.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_tb.sv
